### rtl/cefs_pkg.sv
// ----------------------------------------------------------------------------
// cefs_pkg
// Types, constants and codes shared by the frame scheduler modules.
// ----------------------------------------------------------------------------
package cefs_pkg;

   localparam int MAX_TASKS    = 8;
   localparam int TIME_BITS    = 16;
   localparam int IDX_BITS     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_TASKS + 1);
   localparam int MARK_BITS    = TIME_BITS + 1;
   localparam int LEFT_BITS    = TIME_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(MARK_BITS);

   // Fixed field widths on the ports
   localparam int KIND_W  = 3;
   localparam int INDEX_W = 3;
   localparam int COST_W  = 16;
   localparam int REM_W   = 17;
   localparam int FTIME_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_APPEND  = 2'd1,
      MODE_ADVANCE = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_REJECTED  = 3'd1,
      KIND_SCHEDULED = 3'd2,
      KIND_FRAME_END = 3'd3,
      KIND_FAILED    = 3'd4,
      KIND_OVER      = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      EM_CLEAR,
      EM_APPEND_OK,
      EM_REJECT,
      EM_OVER,
      EM_TASK,
      EM_FRAME
   } emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GCD_TEST,
      ST_GCD_WAIT,
      ST_TASK_TEST,
      ST_REL_WAIT,
      ST_TASK,
      ST_FRAME
   } state_type;

   typedef struct packed {
      logic     load;
      logic     emit;
      emit_type emit_sel;
      logic     clear;
      logic     append;
      logic     gcd_start;
      logic     gcd_step;
      logic     gcd_finish;
      logic     adv_init;
      logic     rel_start;
      logic     task_apply;
      logic     frame_end;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     append_ok;
      logic     minor_zero;
      logic     gcd_b_zero;
      logic     mod_done;
      logic     more_tasks;
      logic     adv_empty;
      logic     task_emit;
      logic     task_fail;
      logic     out_free;
   } sts_type;

endpackage

### rtl/cyclic_executive_frame_scheduler_unit.sv
// ----------------------------------------------------------------------------
// cyclic_executive_frame_scheduler_unit
// Cyclic-executive schedule builder, one minor frame per advance request.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: tuser carries the mode (clear, append,
// advance) and tdata the period and cost of an appended task. Results leave
// on the rsp_ stream, kind in tuser, tlast on the final result of a request.
// One request is worked on at a time; req_tready is high only when idle.
// Clear, rejected and schedule-over requests finish at decode, as does an
// append into an empty table. Any other append then runs the Euclid steps of
// the minor-frame gcd (up to about 24 steps for 16-bit periods) through the
// bit-serial remainder unit. An advance walks the tasks in the table, each
// task needing one release test through the same remainder unit.
// A stalled result stream holds the walk at the next result; the output
// register lets a new request be taken while the last result waits.
// Reset empties the table, clears frame values and progress; no sweep runs.
// ----------------------------------------------------------------------------
module cyclic_executive_frame_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // mode
   input  logic [31:0] req_tdata,   // task_period, task_cost
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   // task_index, cost_out, early, time_remaining, frame_time, zero pad
   output logic [55:0] rsp_tdata
);
   import cefs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cefs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cefs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_mode  (req_tuser),
      .req_data  (req_tdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_last  (rsp_tlast),
      .rsp_data  (rsp_tdata)
   );

endmodule

### rtl/cefs_rem.sv
// ----------------------------------------------------------------------------
// cefs_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cefs_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cefs_pkg::MARK_BITS-1:0] dividend,
   input  logic [cefs_pkg::TIME_BITS-1:0] divisor,
   output logic                          done,
   output logic [cefs_pkg::TIME_BITS-1:0] remainder
);
   import cefs_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [MARK_BITS-1:0]    dvd_ff;
   logic [TIME_BITS-1:0]    rem_ff, rem_in;
   logic [TIME_BITS-1:0]    dsr_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [TIME_BITS:0]      shifted;

   always_comb begin
      shifted = {rem_ff, dvd_ff[MARK_BITS-1]};
      if (shifted >= {1'b0, dsr_ff}) begin
         rem_in = TIME_BITS'(shifted - {1'b0, dsr_ff});
      end else begin
         rem_in = shifted[TIME_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= DIV_CNT_BITS'(MARK_BITS - 1);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[MARK_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/cefs_dp.sv
// ----------------------------------------------------------------------------
// cefs_dp
// Datapath: task tables, frame values, schedule progress and result register.
// ----------------------------------------------------------------------------
module cefs_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  cefs_pkg::cmd_type             cmd,
   output cefs_pkg::sts_type             sts,
   input  logic [1:0]                    req_mode,
   input  logic [cefs_pkg::REQ_DATA_W-1:0] req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cefs_pkg::KIND_W-1:0]   rsp_kind,
   output logic                          rsp_last,
   output logic [cefs_pkg::RSP_DATA_W-1:0] rsp_data
);
   import cefs_pkg::*;

   mode_type              mode_ff;
   logic [TIME_BITS-1:0]  per_ff, cost_ff;
   logic [TIME_BITS-1:0]  period_ff [MAX_TASKS];
   logic [TIME_BITS-1:0]  costtab_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0]  ran_ff;
   logic [CNT_BITS-1:0]   count_ff, idx_ff;
   logic [TIME_BITS-1:0]  minor_ff, major_ff, ga_ff, gb_ff;
   logic [MARK_BITS-1:0]  marker_ff, marker_next;
   logic                  finished_ff;
   logic signed [LEFT_BITS-1:0] left_ff, left_chg;

   logic                  out_valid_ff;
   kind_type              o_kind_ff, o_kind_in;
   logic [INDEX_W-1:0]    o_idx_ff, o_idx_in;
   logic [COST_W-1:0]     o_cost_ff, o_cost_in;
   logic                  o_early_ff, o_early_in;
   logic [REM_W-1:0]      o_rem_ff, o_rem_in;
   logic [FTIME_W-1:0]    o_ftime_ff, o_ftime_in;
   logic                  o_last_ff, o_last_in;

   logic [IDX_BITS-1:0]   cur;
   logic [TIME_BITS-1:0]  cur_p, cur_c;
   logic                  released, neg, mod_done;
   logic [TIME_BITS-1:0]  mod_rem;
   logic [MARK_BITS-1:0]  mod_a;
   logic [TIME_BITS-1:0]  mod_b;

   assign cur      = idx_ff[IDX_BITS-1:0];
   assign cur_p    = period_ff[cur];
   assign cur_c    = costtab_ff[cur];
   assign left_chg = left_ff - $signed({2'b00, cur_c});
   assign neg      = left_chg[LEFT_BITS-1];
   assign released = (cur_p != '0) && (mod_rem == '0);
   assign marker_next = marker_ff + MARK_BITS'(minor_ff);

   assign mod_a = cmd.gcd_start ? {1'b0, ga_ff} : marker_ff;
   assign mod_b = cmd.gcd_start ? gb_ff : cur_p;

   cefs_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.gcd_start | cmd.rel_start),
      .dividend  (mod_a),
      .divisor   (mod_b),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      sts.mode       = mode_ff;
      sts.append_ok  = (per_ff != '0) && (count_ff < CNT_BITS'(MAX_TASKS));
      sts.minor_zero = (minor_ff == '0);
      sts.gcd_b_zero = (gb_ff == '0);
      sts.mod_done   = mod_done;
      sts.more_tasks = (idx_ff < count_ff);
      sts.adv_empty  = finished_ff || (count_ff == '0) || (minor_ff == '0);
      sts.task_emit  = !ran_ff[cur] && (released || !neg);
      sts.task_fail  = released && !ran_ff[cur] && neg;
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   // Captured request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         per_ff  <= TIME_BITS'(req_data[15:0]);
         cost_ff <= TIME_BITS'(req_data[31:16]);
      end
   end

   // Task tables hold no reset; entries are read only below the task count.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         period_ff[count_ff[IDX_BITS-1:0]]  <= per_ff;
         costtab_ff[count_ff[IDX_BITS-1:0]] <= cost_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         minor_ff    <= '0;
         major_ff    <= '0;
         marker_ff   <= '0;
         finished_ff <= 1'b0;
         ran_ff      <= '0;
      end else begin
         if (cmd.clear) begin
            count_ff    <= '0;
            minor_ff    <= '0;
            major_ff    <= '0;
            marker_ff   <= '0;
            finished_ff <= 1'b0;
            ran_ff      <= '0;
         end
         if (cmd.append) begin
            count_ff    <= count_ff + 1'b1;
            marker_ff   <= '0;
            finished_ff <= 1'b0;
            ran_ff      <= '0;
            if (per_ff > major_ff) begin
               major_ff <= per_ff;
            end
            if (minor_ff == '0) begin
               minor_ff <= per_ff;
            end
         end
         if (cmd.gcd_finish) begin
            minor_ff <= ga_ff;
         end
         if (cmd.adv_init && marker_ff == '0) begin
            marker_ff <= MARK_BITS'(minor_ff);
         end
         if (cmd.task_apply) begin
            if (released) begin
               if (ran_ff[cur]) begin
                  ran_ff[cur] <= 1'b0;
               end else if (neg) begin
                  finished_ff <= 1'b1;
               end
            end else if (!ran_ff[cur] && !neg) begin
               ran_ff[cur] <= 1'b1;
            end
         end
         if (cmd.frame_end) begin
            marker_ff   <= marker_next;
            finished_ff <= (marker_next > MARK_BITS'(major_ff));
         end
      end
   end

   // Working values of the gcd and of the frame walk
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         ga_ff <= minor_ff;
         gb_ff <= per_ff;
      end
      if (cmd.gcd_step) begin
         ga_ff <= gb_ff;
         gb_ff <= mod_rem;
      end
      if (cmd.adv_init) begin
         left_ff <= LEFT_BITS'(minor_ff);
         idx_ff  <= '0;
      end
      if (cmd.task_apply) begin
         idx_ff <= idx_ff + 1'b1;
         if ((released && !ran_ff[cur]) || (!released && !ran_ff[cur] && !neg)) begin
            left_ff <= left_chg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      o_kind_in  = KIND_OVER;
      o_idx_in   = '0;
      o_cost_in  = '0;
      o_early_in = 1'b0;
      o_rem_in   = '0;
      o_ftime_in = '0;
      o_last_in  = 1'b1;
      case (cmd.emit_sel)
         EM_CLEAR: begin
            o_kind_in = KIND_ACCEPTED;
         end
         EM_APPEND_OK: begin
            o_kind_in = KIND_ACCEPTED;
            o_idx_in  = INDEX_W'(count_ff);
         end
         EM_REJECT: begin
            o_kind_in  = KIND_REJECTED;
            o_ftime_in = FTIME_W'(marker_ff);
         end
         EM_TASK: begin
            o_kind_in  = sts.task_fail ? KIND_FAILED : KIND_SCHEDULED;
            o_idx_in   = INDEX_W'(idx_ff);
            o_cost_in  = COST_W'(cur_c);
            o_early_in = !released;
            o_rem_in   = REM_W'(left_chg);
            o_ftime_in = FTIME_W'(marker_ff);
            o_last_in  = sts.task_fail;
         end
         EM_FRAME: begin
            o_kind_in  = KIND_FRAME_END;
            o_rem_in   = REM_W'(left_ff);
            o_ftime_in = FTIME_W'(marker_ff);
         end
         default: begin
            o_kind_in = KIND_OVER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_kind_ff  <= o_kind_in;
         o_idx_ff   <= o_idx_in;
         o_cost_ff  <= o_cost_in;
         o_early_ff <= o_early_in;
         o_rem_ff   <= o_rem_in;
         o_ftime_ff <= o_ftime_in;
         o_last_ff  <= o_last_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = o_kind_ff;
   assign rsp_last  = o_last_ff;
   assign rsp_data  = {3'b000, o_ftime_ff, o_rem_ff, o_early_ff, o_cost_ff, o_idx_ff};

endmodule

### rtl/cefs_ctrl.sv
// ----------------------------------------------------------------------------
// cefs_ctrl
// Controller: sequences request decode, gcd iterations and the frame walk.
// ----------------------------------------------------------------------------
module cefs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cefs_pkg::sts_type sts,
   output cefs_pkg::cmd_type cmd
);
   import cefs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
               if (sts.mode == MODE_APPEND && sts.append_ok && !sts.minor_zero) begin
                  state_in = ST_GCD_TEST;
               end
               if (sts.mode == MODE_ADVANCE && !sts.adv_empty) begin
                  state_in = ST_TASK_TEST;
               end
            end
         end
         ST_GCD_TEST: begin
            state_in = sts.gcd_b_zero ? ST_IDLE : ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (sts.mod_done) state_in = ST_GCD_TEST;
         end
         ST_TASK_TEST: begin
            state_in = sts.more_tasks ? ST_REL_WAIT : ST_FRAME;
         end
         ST_REL_WAIT: begin
            if (sts.mod_done) state_in = ST_TASK;
         end
         ST_TASK: begin
            if (!sts.task_emit || sts.out_free) begin
               state_in = sts.task_fail ? ST_IDLE : ST_TASK_TEST;
            end
         end
         ST_FRAME: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.emit_sel = EM_OVER;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            if (sts.out_free) begin
               case (sts.mode)
                  MODE_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EM_CLEAR;
                  end
                  MODE_APPEND: begin
                     cmd.emit     = 1'b1;
                     cmd.append   = sts.append_ok;
                     cmd.emit_sel = sts.append_ok ? EM_APPEND_OK : EM_REJECT;
                  end
                  MODE_ADVANCE: begin
                     cmd.emit     = sts.adv_empty;
                     cmd.adv_init = !sts.adv_empty;
                     cmd.emit_sel = EM_OVER;
                  end
                  default: begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EM_REJECT;
                  end
               endcase
            end
         end
         ST_GCD_TEST: begin
            cmd.gcd_finish = sts.gcd_b_zero;
            cmd.gcd_start  = !sts.gcd_b_zero;
         end
         ST_GCD_WAIT: begin
            cmd.gcd_step = sts.mod_done;
         end
         ST_TASK_TEST: begin
            cmd.rel_start = sts.more_tasks;
         end
         ST_TASK: begin
            if (!sts.task_emit || sts.out_free) begin
               cmd.task_apply = 1'b1;
               cmd.emit       = sts.task_emit;
               cmd.emit_sel   = EM_TASK;
            end
         end
         ST_FRAME: begin
            if (sts.out_free) begin
               cmd.frame_end = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_sel  = EM_FRAME;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A result is only written into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result written while output register occupied");

   // The remainder unit reports completion only while a wait state expects it.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      sts.mod_done |-> (state_ff == ST_GCD_WAIT || state_ff == ST_REL_WAIT))
      else $error("remainder completion outside a wait state");

   // A failing charge ends the request.
   a_fail_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.task_apply && sts.task_fail) |=> state_ff == ST_IDLE)
      else $error("walk continued after a failure");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking test of the cyclic-executive frame scheduler.
// ----------------------------------------------------------------------------
// Builds random task tables, walks their minor frames and checks every result
// against a predictor that keeps its own copy of the task table and schedule
// progress. Requests are sent in bursts; the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
   import cefs_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic [2:0]        index;
      logic [15:0]       cost;
      logic              early;
      logic signed [16:0] remaining;
      logic [15:0]       ftime;
      logic              last;
   } sched_result;

   class schedule_board;
      logic [15:0] periods [MAX_TASKS];
      logic [15:0] costs [MAX_TASKS];
      bit          ahead [MAX_TASKS];
      int          count;
      logic [15:0] minor;
      logic [15:0] major;
      logic [16:0] mark;
      bit          done;
      sched_result pending [$];
      int          errors;

      function void clear_progress();
         foreach (ahead[i]) ahead[i] = 0;
         mark = 0;
         done = 0;
      endfunction

      function void clear_all();
         count = 0;
         minor = 0;
         major = 0;
         clear_progress();
      endfunction

      function void push(kind_type k, int idx, int c, bit e, int r, int f, bit l);
         sched_result s;
         s.kind = k;
         s.index = idx[2:0];
         s.cost = c[15:0];
         s.early = e;
         s.remaining = r[16:0];
         s.ftime = f[15:0];
         s.last = l;
         pending.insert(pending.size(), s);
      endfunction

      function logic [15:0] gcd16(logic [15:0] a, logic [15:0] b);
         logic [15:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // Works out the results of one accepted request.
      function void note_request(mode_type m, logic [15:0] per, logic [15:0] c);
         int left;
         bit rel;
         if (m == MODE_CLEAR) begin
            clear_all();
            push(KIND_ACCEPTED, 0, 0, 0, 0, 0, 1);
         end else if (m == MODE_APPEND) begin
            if (per == 0 || count >= MAX_TASKS) begin
               push(KIND_REJECTED, 0, 0, 0, 0, mark, 1);
            end else begin
               periods[count] = per;
               costs[count] = c;
               minor = (minor == 0) ? per : gcd16(minor, per);
               if (per > major) major = per;
               clear_progress();
               push(KIND_ACCEPTED, count, 0, 0, 0, mark, 1);
               count++;
            end
         end else if (m != MODE_ADVANCE) begin
            push(KIND_REJECTED, 0, 0, 0, 0, mark, 1);
         end else if (done || count == 0 || minor == 0) begin
            push(KIND_OVER, 0, 0, 0, 0, 0, 1);
         end else begin
            if (mark == 0) mark = minor;
            left = minor;
            for (int i = 0; i < count; i++) begin
               rel = (mark % periods[i]) == 0;
               if (rel) begin
                  if (ahead[i]) ahead[i] = 0;
                  else begin
                     left -= costs[i];
                     if (left < 0) begin
                        done = 1;
                        push(KIND_FAILED, i, costs[i], 0, left, mark, 1);
                        return;
                     end
                     push(KIND_SCHEDULED, i, costs[i], 0, left, mark, 0);
                  end
               end else if (!ahead[i] && left - int'(costs[i]) >= 0) begin
                  left -= costs[i];
                  ahead[i] = 1;
                  push(KIND_SCHEDULED, i, costs[i], 1, left, mark, 0);
               end
            end
            push(KIND_FRAME_END, 0, 0, 0, left, mark, 1);
            mark += minor;
            if (mark > major) done = 1;
         end
      endfunction

      function void check_result(sched_result got);
         sched_result want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = 0;
   logic [31:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic [55:0] rsp_tdata;

   schedule_board board;
   int idle_cycles = 0;
   int burst_left = 0;
   bit stim_done = 0;

   cyclic_executive_frame_scheduler_unit dut (.*);

   always #2 clock = ~clock;

   // Accepted requests feed the predictor; accepted results are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(mode_type'(req_tuser), req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            board.check_result({kind_type'(rsp_tuser), rsp_tdata[2:0], rsp_tdata[18:3],
                                rsp_tdata[19], rsp_tdata[36:20], rsp_tdata[52:37],
                                rsp_tlast});
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("cyclic_executive_frame_scheduler_unit test failed");
            $finish;
         end
      end
   end

   // The result side stalls at random, and never once the stimulus is done.
   always @(negedge clock) begin
      int phase;
      phase = $urandom_range(0, 99);
      if (stim_done || (phase % 40) < 20) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // Within a burst the next request follows at the same falling edge.
   task automatic send_request(mode_type m, logic [15:0] per, logic [15:0] c);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser <= m;
      req_tdata <= {c, per};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      burst_left = 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // Builds a well-formed table whose periods share a small base, then walks it.
   task automatic random_schedule();
      int n;
      int base;
      int frames;
      n = $urandom_range(1, MAX_TASKS);
      base = $urandom_range(1, 5);
      send_request(MODE_CLEAR, 16'($urandom), 16'($urandom));
      for (int i = 0; i < n; i++)
         send_request(MODE_APPEND, 16'(base * $urandom_range(1, 6)),
                      16'($urandom_range(0, 3 * base)));
      frames = $urandom_range(2, 12);
      for (int f = 0; f < frames; f++) begin
         if ($urandom_range(0, 15) == 0)
            send_request(mode_type'($urandom_range(0, 3)), 16'($urandom),
                         16'($urandom));
         else send_request(MODE_ADVANCE, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      board = new();
      board.clear_all();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Directed: empty advance, zero period, single task, full table, extremes.
      send_request(MODE_ADVANCE, 0, 0);
      send_request(MODE_APPEND, 0, 16'hFFFF);
      send_request(MODE_APPEND, 16'hFFFF, 16'hFFFF);
      send_request(MODE_ADVANCE, 0, 0);
      send_request(MODE_ADVANCE, 0, 0);
      send_request(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(MODE_CLEAR, 0, 0);
      for (int i = 0; i < 9; i++) send_request(MODE_APPEND, 16'(4 << (i % 3)), 16'(i % 2));
      send_request(MODE_ADVANCE, 0, 0);
      send_request(MODE_APPEND, 16'h8000, 0);
      send_request(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
      send_request(MODE_APPEND, 6, 7);
      send_request(MODE_APPEND, 4, 0);
      send_request(MODE_ADVANCE, 0, 0);
      wait_drained();
      for (int r = 0; r < 11; r++) random_schedule();
      stim_done = 1;
      wait_drained();
      if (board.errors == 0)
         $display("cyclic_executive_frame_scheduler_unit test passed");
      else
         $display("cyclic_executive_frame_scheduler_unit test failed");
      $finish;
   end
endmodule
